// ===== src/sepbb_pkg.sv =====
// Shared types, constants and the small-divisor reciprocal table of the alpha box blur.
// No dependencies; sepbb_front, sepbb_back and the top module import this package.
package sepbb_pkg;

    // Fixed field widths (sized for the largest supported radius of 4)
    localparam int XW          = 11;  // column / row counters
    localparam int SUM_W       = 12;  // up to 9 taps of 8 bits
    localparam int CNT_W       = 4;   // up to 9 taps
    localparam int SLOT_W      = 3;   // up to 8 line stores
    localparam int MASK_W      = 8;   // one bit per line store row
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [XW-1:0] WIDTH_RESET  = 11'd64;
    localparam logic [XW-1:0] HEIGHT_RESET = 11'd64;
    localparam logic [XW-1:0] HEIGHT_MAX   = 11'd1024;

    // Input beat
    typedef struct packed {
        logic       mode;
        logic [7:0] alpha_in;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [7:0] alpha_out;
        logic       last_of_run;
        logic       frame_done;
    } t_out;

    // Job handed from the front end to the back end
    typedef struct packed {
        logic              hvalid;     // horizontal result belongs to the image
        logic              emit;       // job produces an output pixel
        logic              frame_done; // last output pixel of the frame
        logic [XW-1:0]     x;          // column of the horizontal result
        logic [SLOT_W-1:0] slot;       // line store of the horizontal result row
        logic [MASK_W-1:0] vmask;      // stored rows inside the image, oldest first
        logic [SUM_W-1:0]  hsum;
        logic [CNT_W-1:0]  hcnt;
    } t_job;

    // ceil(2^20 / cnt); exact quotient for any 12-bit dividend
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 21'd1048576;
            4'd2:    m = 21'd524288;
            4'd3:    m = 21'd349526;
            4'd4:    m = 21'd262144;
            4'd5:    m = 21'd209716;
            4'd6:    m = 21'd174763;
            4'd7:    m = 21'd149797;
            4'd8:    m = 21'd131072;
            4'd9:    m = 21'd116509;
            default: m = '0;
        endcase
        return m;
    endfunction

    // Truncating average: one multiply by the reciprocal, then a shift
    function automatic logic [7:0] f_div(input logic [SUM_W-1:0] sum,
                                         input logic [CNT_W-1:0] cnt);
        logic [SUM_W+RECIP_W-1:0] prod;
        prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(f_recip(cnt));
        return prod[RECIP_SHIFT +: 8];
    endfunction

endpackage

// ===== src/sepbb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port (read-first).
// No dependencies.
module sepbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/sepbb_fifo.sv =====
// Small synchronous FIFO with occupancy count, used for the job queue and result queue.
// No dependencies.
module sepbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ===== src/sepbb_front.sv =====
// Front end: configuration registers, frame position counters, tap window and the
// horizontal tap sum; classifies each beat and queues a job. Depends on sepbb_pkg.
module sepbb_front
    import sepbb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_in                   i_in,
    input  logic                  i_job_full,
    output logic                  o_job_push,
    output t_job                  o_job
);
    localparam int TAPS   = 2 * RADIUS;
    localparam int LEAD_W = $clog2(RADIUS + 1);
    localparam int SW     = $clog2(TAPS);
    localparam int WCAP   = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam logic [XW-1:0] WCAP_V = XW'(WCAP);

    logic [XW-1:0]     r_width, n_width;
    logic [XW-1:0]     r_height, n_height;
    logic [XW-1:0]     r_tx, n_tx;
    logic [XW-1:0]     r_ty, n_ty;
    logic [LEAD_W-1:0] r_lead, n_lead;
    logic [XW-1:0]     r_hx, n_hx;
    logic [XW-1:0]     r_hy, n_hy;
    logic [SW-1:0]     r_slot, n_slot;
    logic [7:0]        r_tap [TAPS];
    logic [7:0]        n_tap [TAPS];

    logic [XW-1:0]     eff_w, eff_h;
    logic [XW:0]       hy_ext, eff_h_ext, eff_w_ext;
    logic              accept, cfg_hit, restart;
    logic [7:0]        v;
    logic [7:0]        taps_all [TAPS+1];
    logic              cvalid, hvalid, emit, frame_done;
    logic [SUM_W-1:0]  h_sum;
    logic [CNT_W-1:0]  h_cnt;
    logic [MASK_W-1:0] vmask;

    // clamp the configured size to the supported range
    always_comb begin
        if (r_width == '0) begin
            eff_w = XW'(1);
        end else if (r_width > WCAP_V) begin
            eff_w = WCAP_V;
        end else begin
            eff_w = r_width;
        end
        if (r_height == '0) begin
            eff_h = XW'(1);
        end else if (r_height > HEIGHT_MAX) begin
            eff_h = HEIGHT_MAX;
        end else begin
            eff_h = r_height;
        end
    end

    assign hy_ext    = {1'b0, r_hy};
    assign eff_h_ext = {1'b0, eff_h};
    assign eff_w_ext = {1'b0, eff_w};
    assign accept    = i_push && !i_job_full;

    // pixel value: zero for drain beats and anything past the frame input
    assign v = (r_ty < eff_h && !i_in.mode) ? i_in.alpha_in : 8'd0;

    // classification of the horizontal center (RADIUS beats behind the input)
    assign cvalid     = (r_lead == LEAD_W'(RADIUS));
    assign hvalid     = cvalid && (r_hy < eff_h);
    assign emit       = cvalid && (hy_ext >= (XW+1)'(RADIUS))
                        && (hy_ext < eff_h_ext + (XW+1)'(RADIUS));
    assign frame_done = cvalid && (hy_ext == eff_h_ext - (XW+1)'(1) + (XW+1)'(RADIUS))
                        && (r_hx == eff_w - XW'(1));

    // taps oldest first, the current pixel last
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            taps_all[k] = r_tap[TAPS-1-k];
        end
        taps_all[TAPS] = v;
    end

    // horizontal sum over taps that stay inside the center's row
    always_comb begin
        logic [XW:0] pos;
        h_sum = '0;
        h_cnt = '0;
        for (int k = 0; k <= TAPS; k++) begin
            pos = {1'b0, r_hx} + (XW+1)'(k);
            if (pos >= (XW+1)'(RADIUS) && pos < eff_w_ext + (XW+1)'(RADIUS)) begin
                h_sum = h_sum + SUM_W'(taps_all[k]);
                h_cnt = h_cnt + CNT_W'(1);
            end
        end
    end

    // stored rows hy-2R .. hy-1 that lie inside the image
    always_comb begin
        logic [XW:0] row;
        for (int j = 0; j < MASK_W; j++) begin
            row = hy_ext + (XW+1)'(j);
            if (j < TAPS) begin
                vmask[j] = (row >= (XW+1)'(TAPS)) && (row < eff_h_ext + (XW+1)'(TAPS));
            end else begin
                vmask[j] = 1'b0;
            end
        end
    end

    // job toward the back end
    assign o_job_push       = accept && (hvalid || emit);
    assign o_job.hvalid     = hvalid;
    assign o_job.emit       = emit;
    assign o_job.frame_done = frame_done;
    assign o_job.x          = r_hx;
    assign o_job.slot       = SLOT_W'(r_slot);
    assign o_job.vmask      = vmask;
    assign o_job.hsum       = h_sum;
    assign o_job.hcnt       = h_cnt;

    assign cfg_hit = i_cfg_we
                     && (i_cfg_idx == CFG_IMAGE_WIDTH || i_cfg_idx == CFG_IMAGE_HEIGHT);
    assign restart = cfg_hit || (accept && frame_done);

    // next state of position counters and tap window
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_lead   = r_lead;
        n_hx     = r_hx;
        n_hy     = r_hy;
        n_slot   = r_slot;
        n_tap    = r_tap;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  n_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
        end
        if (restart) begin
            n_tx   = '0;
            n_ty   = '0;
            n_lead = '0;
            n_hx   = '0;
            n_hy   = '0;
            n_slot = '0;
            for (int i = 0; i < TAPS; i++) begin
                n_tap[i] = 8'd0;
            end
        end else if (accept) begin
            n_tap[0] = v;
            for (int i = 1; i < TAPS; i++) begin
                n_tap[i] = r_tap[i-1];
            end
            // input position, row count saturates once the frame input is over
            if (r_tx == eff_w - XW'(1)) begin
                n_tx = '0;
                if (r_ty < eff_h) begin
                    n_ty = r_ty + XW'(1);
                end
            end else begin
                n_tx = r_tx + XW'(1);
            end
            // center position
            if (!cvalid) begin
                n_lead = r_lead + LEAD_W'(1);
            end else if (r_hx == eff_w - XW'(1)) begin
                n_hx   = '0;
                n_hy   = r_hy + XW'(1);
                n_slot = (r_slot == SW'(TAPS-1)) ? '0 : r_slot + SW'(1);
            end else begin
                n_hx = r_hx + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_tx     <= '0;
            r_ty     <= '0;
            r_lead   <= '0;
            r_hx     <= '0;
            r_hy     <= '0;
            r_slot   <= '0;
            for (int i = 0; i < TAPS; i++) begin
                r_tap[i] <= 8'd0;
            end
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_lead   <= n_lead;
            r_hx     <= n_hx;
            r_hy     <= n_hy;
            r_slot   <= n_slot;
            r_tap    <= n_tap;
        end
    end
endmodule

// ===== src/sepbb_back.sv =====
// Back end: horizontal divide, line stores, vertical sum and divide, result push.
// Depends on sepbb_pkg, sepbb_ram.
module sepbb_back
    import sepbb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2,
    parameter int OUT_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_empty,
    input  t_job                           i_job,
    output logic                           o_job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_push,
    output t_out                           o_out
);
    localparam int TAPS = 2 * RADIUS;
    localparam int SW   = $clog2(TAPS);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int OCW  = $clog2(OUT_DEPTH + 1);

    // stage 1: horizontal result, line store read data arriving
    logic              r_s1_vld;
    logic              r_s1_hvalid, r_s1_emit, r_s1_done;
    logic [XW-1:0]     r_s1_x;
    logic [SW-1:0]     r_s1_slot;
    logic [MASK_W-1:0] r_s1_vmask;
    logic [7:0]        r_s1_hval;
    // stage 2: vertical sum
    logic              r_s2_vld;
    logic              r_s2_emit, r_s2_done;
    logic [SUM_W-1:0]  r_s2_vsum;
    logic [CNT_W-1:0]  r_s2_vcnt;
    // last line store write, forwarded over the read-first RAM
    logic              r_wr_vld;
    logic [SW-1:0]     r_wr_slot;
    logic [XW-1:0]     r_wr_x;
    logic [7:0]        r_wr_data;

    logic [OCW:0]      in_use;
    logic              credit_ok;
    logic [TAPS-1:0]   wr_en;
    logic [7:0]        rd_data  [TAPS];
    logic [7:0]        row_data [TAPS];
    logic [SUM_W-1:0]  s1_vsum;
    logic [CNT_W-1:0]  s1_vcnt;

    // output queue credit: queued results plus emitting jobs in flight
    assign in_use = {1'b0, i_out_count}
                    + (OCW+1)'(r_s1_vld && r_s1_emit)
                    + (OCW+1)'(r_s2_vld && r_s2_emit);
    assign credit_ok = (in_use < (OCW+1)'(OUT_DEPTH));
    assign o_job_pop = !i_job_empty && (!i_job.emit || credit_ok);

    // one line store per stored row
    for (genvar s = 0; s < TAPS; s++) begin : g_line
        assign wr_en[s] = r_s1_vld && r_s1_hvalid && (r_s1_slot == SW'(s));

        sepbb_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (wr_en[s]),
            .i_waddr (AW'(r_s1_x)),
            .i_wdata (r_s1_hval),
            .i_re    (o_job_pop),
            .i_raddr (AW'(i_job.x)),
            .o_rdata (rd_data[s])
        );

        assign row_data[s] = (r_wr_vld && r_wr_slot == SW'(s) && r_wr_x == r_s1_x)
                             ? r_wr_data : rd_data[s];
    end

    // vertical sum over stored rows (oldest at vmask bit 0) and the new row
    always_comb begin
        logic [SW:0] idx;
        s1_vsum = r_s1_hvalid ? SUM_W'(r_s1_hval) : '0;
        s1_vcnt = CNT_W'(r_s1_hvalid);
        for (int j = 0; j < TAPS; j++) begin
            idx = {1'b0, r_s1_slot} + (SW+1)'(j);
            if (idx >= (SW+1)'(TAPS)) begin
                idx = idx - (SW+1)'(TAPS);
            end
            if (r_s1_vmask[j]) begin
                s1_vsum = s1_vsum + SUM_W'(row_data[idx[SW-1:0]]);
                s1_vcnt = s1_vcnt + CNT_W'(1);
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_wr_vld <= 1'b0;
        end else begin
            r_s1_vld <= o_job_pop;
            r_s2_vld <= r_s1_vld;
            if (|wr_en) begin
                r_wr_vld <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_hvalid <= i_job.hvalid;
            r_s1_emit   <= i_job.emit;
            r_s1_done   <= i_job.frame_done;
            r_s1_x      <= i_job.x;
            r_s1_slot   <= SW'(i_job.slot);
            r_s1_vmask  <= i_job.vmask;
            r_s1_hval   <= f_div(i_job.hsum, i_job.hcnt);
        end
        if (r_s1_vld) begin
            r_s2_emit <= r_s1_emit;
            r_s2_done <= r_s1_done;
            r_s2_vsum <= s1_vsum;
            r_s2_vcnt <= s1_vcnt;
        end
        if (|wr_en) begin
            r_wr_slot <= r_s1_slot;
            r_wr_x    <= r_s1_x;
            r_wr_data <= r_s1_hval;
        end
    end

    // result beat
    assign o_out_push        = r_s2_vld && r_s2_emit;
    assign o_out.alpha_out   = f_div(r_s2_vsum, r_s2_vcnt);
    assign o_out.last_of_run = 1'b1;
    assign o_out.frame_done  = r_s2_done;

    // credit scheme must keep the result queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_count < OCW'(OUT_DEPTH)))
        else $error("result queue overflow");

    // an emitting job always has at least one row inside the image
    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_emit) |-> (s1_vcnt != '0))
        else $error("vertical window empty");

    // the front end only queues jobs that write a row or emit a pixel
    a_useful_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_s1_hvalid || r_s1_emit))
        else $error("job with no effect");
endmodule

// ===== src/separable_box_blur_alpha.sv =====
// Separable edge-normalized box blur of an 8-bit alpha raster. Pixels enter one beat per
// clock in row-major order; result pixel p comes out for the input beat at position
// p + RADIUS*width + RADIUS, so drain beats (mode 1) after the frame flush the last
// RADIUS rows. The front end takes one beat per clock while its job queue has room; the
// back end takes one job per clock while the result queue has credit, so the sustained
// rate is one beat per clock. Line stores are 2*RADIUS RAMs of MAX_WIDTH entries, one
// read and one write each per clock; rows are always written before they are read, so
// there is no clearing pass.
// Writing image_width or image_height restarts the frame; write only while idle.
module separable_box_blur_alpha
    import sepbb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_in                   i_in,
    output logic                  empty,
    input  logic                  pop,
    output t_out                  o_out
);
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int OCW       = $clog2(OUT_DEPTH + 1);

    logic                         job_push, job_pop, job_empty;
    t_job                         job_in, job_out;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
    logic                         res_push, res_full;
    t_out                         res_in;
    logic [OCW-1:0]               res_count;

    // front end: counters, tap window, horizontal sum
    sepbb_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in       (i_in),
        .i_job_full (full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // job queue between the two halves
    sepbb_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty),
        .o_count (job_count)
    );

    // back end: line stores and vertical pass
    sepbb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_count (res_count),
        .o_out_push  (res_push),
        .o_out       (res_in)
    );

    // result queue toward the consumer
    sepbb_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty),
        .o_count (res_count)
    );

    // queue depth and fullness cross-check
    a_job_q_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (job_count == ($clog2(JOB_DEPTH+1))'(JOB_DEPTH)))
        else $error("job queue full flag and count disagree");

    a_res_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_res_q_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.frame_done) |-> o_out.last_of_run)
        else $error("frame end without run end");
endmodule
